/* src/signed_int_to_decimal_ascii_top_defines.svh */
// assertion macros for the signed integer to decimal text converter
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define S2DEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define S2DEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/s2dec_pkg.sv */
// shared constants and control types for the decimal text converter
package s2dec_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int SHIFT_W    = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic             load;
    logic             shift;
    logic             emit;
    logic             emit_sign;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic             neg;
    logic [IDX_W-1:0] top_idx;
  } dp_stat_t;

endpackage

/* src/s2dec_dp.sv */
// datapath: magnitude, shift-and-add-3 bcd conversion, character register
module s2dec_dp
  import s2dec_pkg::*;
(
  input  logic                clk,
  input  logic [VALUE_W-1:0]  value,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [CHAR_W-1:0]   text_char
);

  logic                 neg;
  logic [VALUE_W-1:0]   mag;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     adj;
  logic [DIGIT_W-1:0]   digit;
  logic [IDX_W-1:0]     top_idx;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // highest nonzero digit, zero when all digits are zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign digit        = bcd[cmd.idx*DIGIT_W +: DIGIT_W];
  assign stat.neg     = neg;
  assign stat.top_idx = top_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[VALUE_W-1];
      mag <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
      bcd <= '0;
    end else if (cmd.shift) begin
      bcd <= {adj[BCD_W-2:0], mag[VALUE_W-1]};
      mag <= {mag[VALUE_W-2:0], 1'b0};
    end
    if (cmd.emit) begin
      text_char <= cmd.emit_sign ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(digit));
    end
  end

endmodule

/* src/s2dec_ctrl.sv */
// controller: conversion sequencing and character emission
module s2dec_ctrl
  import s2dec_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     last_char,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t             state;
  logic [SHIFT_W-1:0] cnt;
  logic [IDX_W-1:0]   didx;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.shift     = (state == S_CONV);
    cmd.emit      = out_free && (((state == S_SIGN) && stat.neg) || (state == S_EMIT));
    cmd.emit_sign = (state == S_SIGN);
    cmd.idx       = didx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      didx      <= '0;
      out_valid <= 1'b0;
      last_char <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cnt   <= '0;
            state <= S_CONV;
          end
        end
        S_CONV: begin
          cnt <= cnt + SHIFT_W'(1);
          if (cnt == SHIFT_W'(VALUE_W - 1)) begin
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (!stat.neg) begin
            didx  <= stat.top_idx;
            state <= S_EMIT;
          end else if (out_free) begin
            last_char <= 1'b0;
            didx      <= stat.top_idx;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            last_char <= (didx == '0);
            if (didx == '0) begin
              state <= S_IDLE;
            end else begin
              didx <= didx - IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/signed_int_to_decimal_ascii_top.sv */
// top level: signed 32-bit integer to decimal ascii text converter
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   input   | in_valid / in_ready  | value[31:0], two's complement
//   output  | out_valid / out_ready| text_char[7:0], last_char
//
// a value is accepted only while the controller is idle, then shift-and-add-3,
// one step per magnitude bit, turns the magnitude into ten bcd digits
// then the sign stage (emits '-' for a negative value), then one character
// per cycle while out_ready allows, leading zeros skipped, last one flagged
// out_ready low stalls emission in place; the last character sits in the
// output register while the next value is already accepted
// rst is synchronous and clears the controller and the output valid
`include "signed_int_to_decimal_ascii_top_defines.svh"

module signed_int_to_decimal_ascii_top
  import s2dec_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VALUE_W-1:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   text_char,
  output logic                last_char
);

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing, counters and output handshake
  s2dec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .last_char (last_char),
    .stat      (stat),
    .cmd       (cmd)
  );

  // magnitude, bcd conversion, character register
  s2dec_dp u_dp (
    .clk       (clk),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .text_char (text_char)
  );

  // an accepted item keeps the converter busy on the next cycle
  `S2DEC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while converting")

  // a minus sign is never the final character
  `S2DEC_ASSERT_NOW(a_sign_not_last, out_valid && (text_char == CHAR_MINUS), !last_char, "sign flagged last")

  // shown characters are a minus sign or a decimal digit
  `S2DEC_ASSERT_NOW(a_char_legal, out_valid, (text_char == CHAR_MINUS) || ((text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE)), "illegal character")

endmodule
